FILE: rtl/core/mcfsm_pkg.sv
// mcfsm_pkg: widths, reset values, codes and control structs of the frame set matcher
// no dependencies; used by the interfaces, mcfsm_hist and the top level
package mcfsm_pkg;

    localparam int unsigned STAMP_W   = 63;
    localparam int unsigned CAM_ID_W  = 2;
    localparam int unsigned LIMIT_W   = 40;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned CFG_IDX_W = 1;

    localparam int unsigned HISTORY_DEPTH_DEF = 8;
    localparam int unsigned NUM_CAMERAS_DEF   = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 40'd1000000;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SKEW_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LEN    = 1'b1;

    typedef enum logic [1:0] {
        SET_ACCEPTED   = 2'd0,
        SET_DROPPED    = 2'd1,
        SET_INCOMPLETE = 2'd2
    } t_set_status;

    typedef struct packed {
        logic push;
        logic scan;
    } t_hist_cmd;

    typedef struct packed {
        logic empty;
        logic done;
    } t_hist_sts;

endpackage

FILE: rtl/core/mcfsm_if.sv
// mcfsm_in_if and mcfsm_out_if: valid/ready channels of the frame set matcher
// depends on mcfsm_pkg for field widths
interface mcfsm_in_if;
    logic                             valid;
    logic                             ready;
    logic [mcfsm_pkg::CAM_ID_W-1:0]   camera_id;
    logic [mcfsm_pkg::STAMP_W-1:0]    frame_stamp;

    modport source (output valid, output camera_id, output frame_stamp, input ready);
    modport sink   (input valid, input camera_id, input frame_stamp, output ready);
endinterface

interface mcfsm_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     set_status;
    logic [mcfsm_pkg::STAMP_W-1:0]  set_skew;
    logic [mcfsm_pkg::STAMP_W-1:0]  match_cam1;
    logic [mcfsm_pkg::STAMP_W-1:0]  match_cam2;
    logic [mcfsm_pkg::STAMP_W-1:0]  match_cam3;
    logic [mcfsm_pkg::COUNT_W-1:0]  total_sets;
    logic [mcfsm_pkg::COUNT_W-1:0]  total_dropped;
    logic [mcfsm_pkg::STAMP_W-1:0]  worst_accepted_skew;

    modport source (output valid, output set_status, output set_skew, output match_cam1,
                    output match_cam2, output match_cam3, output total_sets,
                    output total_dropped, output worst_accepted_skew, input ready);
    modport sink   (input valid, input set_status, input set_skew, input match_cam1,
                    input match_cam2, input match_cam3, input total_sets,
                    input total_dropped, input worst_accepted_skew, output ready);
endinterface

FILE: rtl/core/mcfsm_hist.sv
// mcfsm_hist: stamp history memory with per-camera ring pointers and fill counts,
// plus the nearest-stamp scan pipeline; depends on mcfsm_pkg
module mcfsm_hist #(
    parameter int unsigned HISTORY_DEPTH = mcfsm_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned NUM_CAMERAS   = mcfsm_pkg::NUM_CAMERAS_DEF,
    localparam int unsigned CAM_W        = $clog2(NUM_CAMERAS),
    localparam int unsigned FILL_W       = $clog2(HISTORY_DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mcfsm_pkg::t_hist_cmd            i_cmd,
    input  logic [CAM_W-1:0]                i_cam,
    input  logic [mcfsm_pkg::STAMP_W-1:0]   i_stamp,
    input  logic [FILL_W-1:0]               i_eff_len,
    output mcfsm_pkg::t_hist_sts            o_sts,
    output logic [mcfsm_pkg::STAMP_W-1:0]   o_best
);

    localparam int unsigned STAMP_W = mcfsm_pkg::STAMP_W;
    localparam int unsigned SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned ROWS    = (NUM_CAMERAS - 1) * HISTORY_DEPTH;
    localparam int unsigned ADDR_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [CAM_W-1:0] cam,
                                                 input logic [SLOT_W-1:0] slot);
        logic [31:0] a;
        a = (32'(cam) - 32'd1) * HISTORY_DEPTH + 32'(slot);
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] f_next_slot(input logic [SLOT_W-1:0] slot);
        return (32'(slot) == HISTORY_DEPTH - 1) ? '0 : slot + 1'b1;
    endfunction

    logic [STAMP_W-1:0] r_mem [ROWS];
    logic [FILL_W-1:0]  r_fill [NUM_CAMERAS];
    logic [SLOT_W-1:0]  r_wp [NUM_CAMERAS];

    logic               r_busy;
    logic [FILL_W-1:0]  r_k;
    logic [FILL_W-1:0]  r_n;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_rd_v;
    logic [STAMP_W-1:0] r_q;
    logic               r_dv;
    logic [STAMP_W-1:0] r_d;
    logic [STAMP_W-1:0] r_dt;
    logic               r_have;
    logic [STAMP_W-1:0] r_best;
    logic [STAMP_W-1:0] r_best_d;

    logic [FILL_W-1:0]  w_cur_fill;
    logic [SLOT_W-1:0]  w_cur_wp;
    logic [FILL_W-1:0]  w_next_fill;
    logic [31:0]        w_start_sum;
    logic [SLOT_W-1:0]  w_start_slot;
    logic               w_issue;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [STAMP_W:0]   w_up;
    logic [STAMP_W:0]   w_dn;
    logic [STAMP_W-1:0] w_abs;
    logic               w_done;

    assign w_cur_fill   = r_fill[i_cam];
    assign w_cur_wp     = r_wp[i_cam];
    assign w_next_fill  = (w_cur_fill < i_eff_len) ? w_cur_fill + 1'b1 : i_eff_len;
    assign w_start_sum  = 32'(w_cur_wp) + HISTORY_DEPTH - 32'(w_cur_fill);
    assign w_start_slot = (w_start_sum >= HISTORY_DEPTH)
                        ? SLOT_W'(w_start_sum - HISTORY_DEPTH) : SLOT_W'(w_start_sum);
    assign w_issue      = r_busy && (r_k != r_n);
    assign w_rd_addr    = f_addr(i_cam, r_slot);

    // distance of the fetched stamp to the reference stamp
    assign w_up  = {1'b0, r_q} - {1'b0, i_stamp};
    assign w_dn  = {1'b0, i_stamp} - {1'b0, r_q};
    assign w_abs = w_up[STAMP_W] ? w_dn[STAMP_W-1:0] : w_up[STAMP_W-1:0];

    assign w_done    = r_busy && (r_k == r_n) && !r_rd_v && !r_dv;
    assign o_sts.done  = w_done;
    assign o_sts.empty = (w_cur_fill == '0);
    assign o_best      = r_best;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[f_addr(i_cam, w_cur_wp)] <= i_stamp;
        end
        if (w_issue) begin
            r_q <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CAMERAS; c++) begin
                r_fill[c] <= '0;
                r_wp[c]   <= '0;
            end
            r_busy <= 1'b0;
            r_k    <= '0;
            r_rd_v <= 1'b0;
            r_dv   <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_wp[i_cam]   <= f_next_slot(w_cur_wp);
                r_fill[i_cam] <= w_next_fill;
            end
            r_rd_v <= w_issue;
            r_dv   <= r_rd_v;
            if (i_cmd.scan) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else begin
                if (w_issue) begin
                    r_k <= r_k + 1'b1;
                end
                if (w_done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // oldest entry first, strict compare keeps the oldest on a tie
    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_d  <= w_abs;
            r_dt <= r_q;
        end
        if (r_dv && (!r_have || r_d < r_best_d)) begin
            r_best   <= r_dt;
            r_best_d <= r_d;
            r_have   <= 1'b1;
        end
        if (i_cmd.scan) begin
            r_n    <= w_cur_fill;
            r_slot <= w_start_slot;
            r_have <= 1'b0;
        end else if (w_issue) begin
            r_slot <= f_next_slot(r_slot);
        end
    end

endmodule

FILE: rtl/core/multi_camera_frame_set_matcher_core.sv
// multi_camera_frame_set_matcher_core: top level, sequencer, counters and result register
// depends on mcfsm_pkg, mcfsm_if.sv and mcfsm_hist
//
//   channel   dir  modport  payload
//   i_frame   in   sink     camera_id, frame_stamp
//   o_set     out  source   set_status, set_skew, match_cam1..3, counters, worst skew
//   i_cfg_*   in   -        write enable, register index, 40-bit data
//
// secondary frame: accept, then history write
// reference frame: for each secondary camera a check and a scan of its ring through the
// single read port of the history memory, then skew, judge and emit
// an incomplete set ends at the first empty camera; the result register lets the next
// frame be taken while a result waits; synchronous active-low reset, no clearing pass
module multi_camera_frame_set_matcher_core #(
    parameter int unsigned HISTORY_DEPTH = mcfsm_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned NUM_CAMERAS   = mcfsm_pkg::NUM_CAMERAS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mcfsm_in_if.sink                          i_frame,
    mcfsm_out_if.source                       o_set,
    input  logic                              i_cfg_we,
    input  logic [mcfsm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mcfsm_pkg::LIMIT_W-1:0]     i_cfg_data
);

    localparam int unsigned STAMP_W = mcfsm_pkg::STAMP_W;
    localparam int unsigned COUNT_W = mcfsm_pkg::COUNT_W;
    localparam int unsigned CAM_W   = $clog2(NUM_CAMERAS);
    localparam int unsigned FILL_W  = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PUSH  = 7'b0000010,
        ST_CHECK = 7'b0000100,
        ST_SCAN  = 7'b0001000,
        ST_SKEW  = 7'b0010000,
        ST_JUDGE = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [mcfsm_pkg::LIMIT_W-1:0]   r_max_skew_limit;
    logic [mcfsm_pkg::LEN_W-1:0]     r_history_len;
    logic [CAM_W-1:0]                r_cam;
    logic [STAMP_W-1:0]              r_t0;
    logic [STAMP_W-1:0]              r_lo;
    logic [STAMP_W-1:0]              r_hi;
    logic [STAMP_W-1:0]              r_match [3];
    logic                            r_incomplete;
    logic [STAMP_W-1:0]              r_skew;
    logic                            r_dropped;
    logic [COUNT_W-1:0]              r_set_cnt;
    logic [COUNT_W-1:0]              r_drop_cnt;
    logic [STAMP_W-1:0]              r_worst;

    logic                            r_ov;
    mcfsm_pkg::t_set_status          r_o_status;
    logic [STAMP_W-1:0]              r_o_skew;
    logic [STAMP_W-1:0]              r_o_match [3];
    logic [COUNT_W-1:0]              r_o_sets;
    logic [COUNT_W-1:0]              r_o_drops;
    logic [STAMP_W-1:0]              r_o_worst;

    mcfsm_pkg::t_hist_cmd            w_cmd;
    mcfsm_pkg::t_hist_sts            w_sts;
    logic [STAMP_W-1:0]              w_best;
    logic [FILL_W-1:0]               w_eff_len;
    logic                            w_in_acc;
    logic                            w_cam_ok;
    logic                            w_cam_ref;
    logic                            w_last_cam;
    logic                            w_emit;

    assign i_frame.ready = i_rst_n && (r_state == ST_IDLE);
    assign w_in_acc      = i_frame.valid && i_frame.ready;
    assign w_cam_ok      = 32'(i_frame.camera_id) < NUM_CAMERAS;
    assign w_cam_ref     = (i_frame.camera_id == '0);
    assign w_last_cam    = (32'(r_cam) == NUM_CAMERAS - 1);
    assign w_emit        = (r_state == ST_EMIT) && (!r_ov || o_set.ready);

    // zero acts as one, values past the memory depth are clipped
    always_comb begin
        if (r_history_len == '0) begin
            w_eff_len = FILL_W'(1);
        end else if (32'(r_history_len) > HISTORY_DEPTH) begin
            w_eff_len = FILL_W'(HISTORY_DEPTH);
        end else begin
            w_eff_len = FILL_W'(r_history_len);
        end
    end

    assign w_cmd.push = (r_state == ST_PUSH);
    assign w_cmd.scan = (r_state == ST_CHECK) && !w_sts.empty;

    mcfsm_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .NUM_CAMERAS   (NUM_CAMERAS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_cam     (r_cam),
        .i_stamp   (r_t0),
        .i_eff_len (w_eff_len),
        .o_sts     (w_sts),
        .o_best    (w_best)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_cam_ok) begin
                    n_state = w_cam_ref ? ST_CHECK : ST_PUSH;
                end
            end
            ST_PUSH: begin
                n_state = ST_IDLE;
            end
            ST_CHECK: begin
                n_state = w_sts.empty ? ST_EMIT : ST_SCAN;
            end
            ST_SCAN: begin
                if (w_sts.done) begin
                    n_state = w_last_cam ? ST_SKEW : ST_CHECK;
                end
            end
            ST_SKEW: begin
                n_state = ST_JUDGE;
            end
            ST_JUDGE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_max_skew_limit <= mcfsm_pkg::LIMIT_RESET;
            r_history_len    <= mcfsm_pkg::LEN_RESET;
            r_cam            <= '0;
            r_incomplete     <= 1'b0;
            r_dropped        <= 1'b0;
            r_set_cnt        <= '0;
            r_drop_cnt       <= '0;
            r_worst          <= '0;
            r_ov             <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mcfsm_pkg::CFG_MAX_SKEW_LIMIT: r_max_skew_limit <= i_cfg_data;
                    mcfsm_pkg::CFG_HISTORY_LEN:
                        r_history_len <= i_cfg_data[mcfsm_pkg::LEN_W-1:0];
                endcase
            end
            if (r_state == ST_IDLE && w_in_acc && w_cam_ok) begin
                r_cam        <= w_cam_ref ? CAM_W'(1) : CAM_W'(i_frame.camera_id);
                r_incomplete <= 1'b0;
            end
            if (r_state == ST_CHECK && w_sts.empty) begin
                r_incomplete <= 1'b1;
            end
            if (r_state == ST_SCAN && w_sts.done && !w_last_cam) begin
                r_cam <= r_cam + 1'b1;
            end
            if (r_state == ST_JUDGE) begin
                if (r_set_cnt != '1) begin
                    r_set_cnt <= r_set_cnt + 1'b1;
                end
                if (r_skew > STAMP_W'(r_max_skew_limit)) begin
                    r_dropped <= 1'b1;
                    if (r_drop_cnt != '1) begin
                        r_drop_cnt <= r_drop_cnt + 1'b1;
                    end
                end else begin
                    r_dropped <= 1'b0;
                    if (r_skew > r_worst) begin
                        r_worst <= r_skew;
                    end
                end
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_set.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_acc) begin
            r_t0 <= i_frame.frame_stamp;
            r_lo <= i_frame.frame_stamp;
            r_hi <= i_frame.frame_stamp;
            for (int j = 0; j < 3; j++) begin
                r_match[j] <= '0;
            end
        end
        if (r_state == ST_SCAN && w_sts.done) begin
            for (int j = 0; j < 3; j++) begin
                if (32'(r_cam) == j + 1) begin
                    r_match[j] <= w_best;
                end
            end
            if (w_best < r_lo) begin
                r_lo <= w_best;
            end
            if (w_best > r_hi) begin
                r_hi <= w_best;
            end
        end
        if (r_state == ST_SKEW) begin
            r_skew <= r_hi - r_lo;
        end
        if (w_emit) begin
            priority if (r_incomplete) begin
                r_o_status <= mcfsm_pkg::SET_INCOMPLETE;
            end else if (r_dropped) begin
                r_o_status <= mcfsm_pkg::SET_DROPPED;
            end else begin
                r_o_status <= mcfsm_pkg::SET_ACCEPTED;
            end
            r_o_skew <= r_incomplete ? '0 : r_skew;
            for (int j = 0; j < 3; j++) begin
                r_o_match[j] <= r_incomplete ? '0 : r_match[j];
            end
            r_o_sets  <= r_set_cnt;
            r_o_drops <= r_drop_cnt;
            r_o_worst <= r_worst;
        end
    end

    assign o_set.valid               = r_ov;
    assign o_set.set_status          = r_o_status;
    assign o_set.set_skew            = r_o_skew;
    assign o_set.match_cam1          = r_o_match[0];
    assign o_set.match_cam2          = r_o_match[1];
    assign o_set.match_cam3          = r_o_match[2];
    assign o_set.total_sets          = r_o_sets;
    assign o_set.total_dropped       = r_o_drops;
    assign o_set.worst_accepted_skew = r_o_worst;

`ifndef SYNTHESIS
    a_drops_within_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_set.valid |-> (o_set.total_dropped <= o_set.total_sets))
        else $error("dropped count exceeds set count");

    a_accepted_within_worst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_set.valid && o_set.set_status == mcfsm_pkg::SET_ACCEPTED)
            |-> (o_set.set_skew <= o_set.worst_accepted_skew))
        else $error("accepted skew above worst accepted skew");

    a_done_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == ST_SCAN))
        else $error("history scan finished outside scan state");

    a_scan_needs_stamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan |=> !w_sts.done)
        else $error("scan finished without reading any stamp");
`endif

endmodule

FILE: dv/tb.sv
// tb: self-checking bench for multi_camera_frame_set_matcher_core, random bursts and stalls
// depends on mcfsm_pkg and the mcfsm_in_if / mcfsm_out_if channel interfaces
// frame beats are predicted on acceptance and every set beat is checked in order
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STAMP_W           = mcfsm_pkg::STAMP_W;
    localparam int unsigned CAM_ID_W          = mcfsm_pkg::CAM_ID_W;
    localparam int unsigned LIMIT_W           = mcfsm_pkg::LIMIT_W;
    localparam int unsigned LEN_W             = mcfsm_pkg::LEN_W;
    localparam int unsigned COUNT_W           = mcfsm_pkg::COUNT_W;
    localparam int unsigned CFG_IDX_W         = mcfsm_pkg::CFG_IDX_W;
    localparam int unsigned HISTORY_DEPTH_DEF = mcfsm_pkg::HISTORY_DEPTH_DEF;
    localparam int unsigned NUM_CAMERAS_DEF   = mcfsm_pkg::NUM_CAMERAS_DEF;

    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned SETTLE_CYCLES  = 60;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned PHASE_FRAMES   = 235;
    localparam int unsigned N_PHASES       = 7;
    localparam int unsigned REPORT_MAX     = 10;
    localparam logic [CAM_ID_W-1:0] CAM_REF   = 2'd0;
    localparam logic [STAMP_W-1:0]  STAMP_MAX = '1;
    localparam logic [STAMP_W-1:0]  FAR_T     = 63'd5000000000000;

    typedef struct {
        logic [CAM_ID_W-1:0] cam;
        logic [STAMP_W-1:0]  stamp;
    } t_frame;

    typedef struct {
        mcfsm_pkg::t_set_status status;
        logic [STAMP_W-1:0]     skew;
        logic [STAMP_W-1:0]     cam1;
        logic [STAMP_W-1:0]     cam2;
        logic [STAMP_W-1:0]     cam3;
        logic [COUNT_W-1:0]     sets;
        logic [COUNT_W-1:0]     dropped;
        logic [STAMP_W-1:0]     worst;
    } t_set_result;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_COIN,
        FLOW_PULSE,
        FLOW_STARVED
    } t_flow;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0]   cfg_data;

    mcfsm_in_if  frame_if ();
    mcfsm_out_if set_if ();

    multi_camera_frame_set_matcher_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_frame     (frame_if),
        .o_set       (set_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // matcher state as the block should hold it
    logic [STAMP_W-1:0] hist_stamp [NUM_CAMERAS_DEF][HISTORY_DEPTH_DEF];
    int unsigned        hist_fill  [NUM_CAMERAS_DEF] = '{default: 0};
    int unsigned        hist_wptr  [NUM_CAMERAS_DEF] = '{default: 0};
    logic [COUNT_W-1:0] sets_seen  = '0;
    logic [COUNT_W-1:0] drops_seen = '0;
    logic [STAMP_W-1:0] worst_skew = '0;
    logic [LIMIT_W-1:0] limit_reg  = mcfsm_pkg::LIMIT_RESET;
    logic [LEN_W-1:0]   len_reg    = mcfsm_pkg::LEN_RESET;

    t_frame      frames_pending [$];
    t_set_result sets_due [$];
    t_frame      next_frame;
    t_set_result due_set;

    int unsigned frames_queued = 0;
    int unsigned burst_left    = 1;
    int unsigned gap_left      = 0;
    int unsigned mismatches    = 0;
    int unsigned idle_cycles   = 0;
    int unsigned flow_left     = 0;
    int unsigned pulse_phase   = 0;
    t_flow       flow_mode     = FLOW_FREE;
    logic [STAMP_W-1:0] scene_time;

    logic [LIMIT_W-1:0] phase_limit [N_PHASES];
    logic [LEN_W-1:0]   phase_len   [N_PHASES];

    function automatic void predict_frame(input logic [CAM_ID_W-1:0] cam,
                                          input logic [STAMP_W-1:0] t0);
        int unsigned len;
        int unsigned first;
        logic [STAMP_W-1:0] matched [NUM_CAMERAS_DEF];
        logic [STAMP_W-1:0] lo, hi, t, d, best_d;
        logic complete;
        t_set_result r;
        if (len_reg == '0) len = 1;
        else if (len_reg > HISTORY_DEPTH_DEF) len = HISTORY_DEPTH_DEF;
        else len = len_reg;
        if (cam != CAM_REF) begin
            hist_stamp[cam][hist_wptr[cam]] = t0;
            hist_wptr[cam] = (hist_wptr[cam] + 1) % HISTORY_DEPTH_DEF;
            hist_fill[cam] = (hist_fill[cam] < len) ? hist_fill[cam] + 1 : len;
            return;
        end
        complete = 1'b1;
        lo = t0;
        hi = t0;
        best_d = '0;
        for (int c = 0; c < NUM_CAMERAS_DEF; c++) matched[c] = '0;
        for (int c = 1; c < NUM_CAMERAS_DEF; c++) begin
            if (hist_fill[c] == 0) complete = 1'b0;
            first = (hist_wptr[c] + HISTORY_DEPTH_DEF - hist_fill[c]) % HISTORY_DEPTH_DEF;
            // oldest first, strict compare keeps the oldest on a tie
            for (int unsigned k = 0; k < hist_fill[c]; k++) begin
                t = hist_stamp[c][(first + k) % HISTORY_DEPTH_DEF];
                d = (t >= t0) ? t - t0 : t0 - t;
                if (k == 0 || d < best_d) begin
                    matched[c] = t;
                    best_d = d;
                end
            end
            if (hist_fill[c] != 0) begin
                if (matched[c] < lo) lo = matched[c];
                if (matched[c] > hi) hi = matched[c];
            end
        end
        r.status = mcfsm_pkg::SET_INCOMPLETE;
        r.skew   = '0;
        r.cam1   = '0;
        r.cam2   = '0;
        r.cam3   = '0;
        if (complete) begin
            r.skew = hi - lo;
            r.cam1 = matched[1];
            r.cam2 = matched[2];
            r.cam3 = matched[3];
            if (sets_seen != '1) sets_seen++;
            if (r.skew > {{(STAMP_W-LIMIT_W){1'b0}}, limit_reg}) begin
                r.status = mcfsm_pkg::SET_DROPPED;
                if (drops_seen != '1) drops_seen++;
            end else begin
                r.status = mcfsm_pkg::SET_ACCEPTED;
                if (r.skew > worst_skew) worst_skew = r.skew;
            end
        end
        r.sets    = sets_seen;
        r.dropped = drops_seen;
        r.worst   = worst_skew;
        sets_due.insert(sets_due.size(), r);
    endfunction

    function automatic logic [STAMP_W-1:0] rand_stamp();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[STAMP_W-1:0];
    endfunction

    function automatic logic [STAMP_W-1:0] jitter(input logic [STAMP_W-1:0] centre,
                                                  input logic [31:0] spread);
        logic [STAMP_W-1:0] off;
        off = {{(STAMP_W-32){1'b0}}, 32'($urandom_range(spread, 0))};
        return ($urandom_range(0, 1) == 0) ? centre + off : centre - off;
    endfunction

    task automatic queue_frame(input logic [CAM_ID_W-1:0] cam, input logic [STAMP_W-1:0] stamp);
        t_frame f;
        f.cam   = cam;
        f.stamp = stamp;
        frames_pending.insert(frames_pending.size(), f);
        frames_queued++;
    endtask

    // wait until every beat is out and the block has had time to go quiet
    task automatic drain();
        while (frames_pending.size() != 0 || frame_if.valid || sets_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
        drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == mcfsm_pkg::CFG_MAX_SKEW_LIMIT) limit_reg = data;
        else len_reg = data[LEN_W-1:0];
    endtask

    // mostly complete rounds around a moving scene time, some noise and missing cameras
    task automatic random_phase(input int unsigned n_frames);
        int unsigned target;
        int unsigned start;
        int unsigned step;
        int unsigned reps;
        logic [CAM_ID_W-1:0] cam;
        logic [31:0] spread;
        target = frames_queued + n_frames;
        queue_frame(CAM_REF, scene_time);
        while (frames_queued < target) begin
            if ($urandom_range(0, 9) == 0) begin
                cam = CAM_ID_W'($urandom_range(0, 3));
                queue_frame(cam, ($urandom_range(0, 1) == 0) ? rand_stamp()
                                                              : jitter(scene_time, $urandom));
            end else begin
                case ($urandom_range(0, 4))
                    0: spread = 32'd0;
                    1: spread = 32'd1000;
                    2: spread = 32'd600000;
                    3: spread = 32'd2000000;
                    default: spread = 32'hFFFF_FFFF;
                endcase
                start = $urandom_range(0, 2);
                step  = $urandom_range(1, 2);
                for (int unsigned n = 0; n < 3; n++) begin
                    cam  = CAM_ID_W'((start + n * step) % 3 + 1);
                    reps = ($urandom_range(0, 7) == 0) ? 0 :
                           ($urandom_range(0, 3) == 0) ? 2 : 1;
                    repeat (reps) queue_frame(cam, jitter(scene_time, spread));
                end
                queue_frame(CAM_REF, jitter(scene_time, spread));
                scene_time = scene_time + 63'd33333333 + STAMP_W'($urandom_range(0, 1000000));
                if ($urandom_range(0, 15) == 0) scene_time = rand_stamp();
            end
        end
    endtask

    // frame driver: bursts of beats with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            frame_if.valid <= 1'b0;
        end else begin
            if (frame_if.valid && frame_if.ready)
                predict_frame(frame_if.camera_id, frame_if.frame_stamp);
            if (!frame_if.valid || frame_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    frame_if.valid <= 1'b0;
                end else if (frames_pending.size() != 0) begin
                    next_frame = frames_pending[0];
                    frames_pending.delete(0);
                    frame_if.valid       <= 1'b1;
                    frame_if.camera_id   <= next_frame.cam;
                    frame_if.frame_stamp <= next_frame.stamp;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    frame_if.valid <= 1'b0;
                end
            end
        end
    end

    // set monitor and stall pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            set_if.ready <= 1'b0;
        end else begin
            if (set_if.valid && set_if.ready) begin
                if (sets_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("set beat with nothing expected: status %0d skew %0d",
                                 set_if.set_status, set_if.set_skew);
                end else begin
                    due_set = sets_due[0];
                    sets_due.delete(0);
                    if (set_if.set_status !== due_set.status || set_if.set_skew !== due_set.skew
                            || set_if.match_cam1 !== due_set.cam1
                            || set_if.match_cam2 !== due_set.cam2
                            || set_if.match_cam3 !== due_set.cam3
                            || set_if.total_sets !== due_set.sets
                            || set_if.total_dropped !== due_set.dropped
                            || set_if.worst_accepted_skew !== due_set.worst) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("set exp: st %0d sk %0d m %0d %0d %0d n %0d d %0d w %0d",
                                     due_set.status, due_set.skew, due_set.cam1, due_set.cam2,
                                     due_set.cam3, due_set.sets, due_set.dropped, due_set.worst);
                            $display("    got: st %0d sk %0d m %0d %0d %0d n %0d d %0d w %0d",
                                     set_if.set_status, set_if.set_skew, set_if.match_cam1,
                                     set_if.match_cam2, set_if.match_cam3, set_if.total_sets,
                                     set_if.total_dropped, set_if.worst_accepted_skew);
                        end
                    end
                end
            end
            if (flow_left == 0) begin
                flow_mode = t_flow'($urandom_range(0, 3));
                flow_left = $urandom_range(32, 256);
            end else begin
                flow_left--;
            end
            case (flow_mode)
                FLOW_FREE: set_if.ready <= 1'b1;
                FLOW_COIN: set_if.ready <= 1'($urandom_range(0, 1));
                FLOW_PULSE: begin
                    set_if.ready <= (pulse_phase == 0);
                    pulse_phase = (pulse_phase + 1) % 4;
                end
                default: set_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if ((frame_if.valid && frame_if.ready) || (set_if.valid && set_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        cfg_we               = 1'b0;
        cfg_index            = mcfsm_pkg::CFG_MAX_SKEW_LIMIT;
        cfg_data             = '0;
        rst_n                = 1'b0;
        phase_limit = '{40'd0, 40'hFF_FFFF_FFFF, 40'd1000000, 40'd2000000, 40'd500,
                        40'd0, 40'd1000000};
        phase_limit[5] = {8'($urandom), 32'($urandom)};
        phase_len   = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd5, 4'd2};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // nothing stored yet, then only one camera stored
        queue_frame(CAM_REF, '0);
        queue_frame(2'd1, 63'd1000);
        queue_frame(CAM_REF, STAMP_MAX);
        // full-range spread
        queue_frame(2'd2, STAMP_MAX);
        queue_frame(2'd3, '0);
        queue_frame(CAM_REF, 63'd100);
        // equal distance either side, oldest must win
        queue_frame(2'd1, 63'd90);
        queue_frame(2'd1, 63'd110);
        queue_frame(2'd2, 63'd100);
        queue_frame(2'd3, 63'd100);
        queue_frame(CAM_REF, 63'd100);
        queue_frame(CAM_REF, STAMP_MAX);
        // skew right on the limit and one past it
        queue_frame(2'd1, FAR_T);
        queue_frame(2'd2, FAR_T);
        queue_frame(2'd3, FAR_T);
        queue_frame(CAM_REF, FAR_T + 63'd1000000);
        queue_frame(CAM_REF, FAR_T + 63'd1000001);

        scene_time = rand_stamp();
        for (int unsigned p = 0; p < N_PHASES; p++) begin
            write_reg(mcfsm_pkg::CFG_HISTORY_LEN, {8'($urandom), 28'($urandom), phase_len[p]});
            write_reg(mcfsm_pkg::CFG_MAX_SKEW_LIMIT, phase_limit[p]);
            random_phase(PHASE_FRAMES);
        end
        drain();
        if (mismatches == 0 && sets_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
